// ===== rtl/fixed_point_q24_8_alu_assert.svh =====
// Assertion macros for the checker file of the fixed-point ALU.
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// Checked only while the block is out of reset.
`define FPALU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fpalu assertion failed");

// Checked at every clock edge, reset included.
`define FPALU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fpalu assertion failed");

`endif

// ===== rtl/fpalu_pkg.sv =====
`timescale 1ns / 1ps

package fpalu_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 8;

    localparam int CMD_BITS  = 4;
    localparam int USER_BITS = 4;

    localparam logic [CMD_BITS-1:0] CMD_ADD      = 4'd0;
    localparam logic [CMD_BITS-1:0] CMD_SUB      = 4'd1;
    localparam logic [CMD_BITS-1:0] CMD_MUL      = 4'd2;
    localparam logic [CMD_BITS-1:0] CMD_DIV      = 4'd3;
    localparam logic [CMD_BITS-1:0] CMD_MIN      = 4'd4;
    localparam logic [CMD_BITS-1:0] CMD_MAX      = 4'd5;
    localparam logic [CMD_BITS-1:0] CMD_FROM_INT = 4'd6;
    localparam logic [CMD_BITS-1:0] CMD_TO_INT   = 4'd7;
    localparam logic [CMD_BITS-1:0] CMD_INC      = 4'd8;
    localparam logic [CMD_BITS-1:0] CMD_DEC      = 4'd9;

    typedef struct packed {
        logic gt;
        logic lt;
        logic eq;
        logic dz;
        logic neg;
        logic is_div;
    } t_flags;

endpackage

// ===== rtl/fpalu_prep.sv =====
`timescale 1ns / 1ps

module fpalu_prep #(
    parameter int WORD_BITS = fpalu_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = fpalu_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [fpalu_pkg::CMD_BITS-1:0]      i_cmd,
    input  logic signed [WORD_BITS-1:0]         i_a,
    input  logic signed [WORD_BITS-1:0]         i_b,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [WORD_BITS-1:0]                o_res,
    output logic [WORD_BITS+FRAC_BITS-1:0]      o_num,
    output logic [WORD_BITS-1:0]                o_den,
    output fpalu_pkg::t_flags                   o_flags
);

    localparam int PW = 2 * WORD_BITS;

    logic                               r1_valid;
    logic [fpalu_pkg::CMD_BITS-1:0]     r1_cmd;
    logic signed [WORD_BITS-1:0]        r1_a;
    logic signed [WORD_BITS-1:0]        r1_b;
    logic signed [PW-1:0]               r1_prod;
    logic signed [PW-1:0]               w_prod;

    logic                               r2_valid;
    logic [WORD_BITS-1:0]               r2_res;
    logic [WORD_BITS+FRAC_BITS-1:0]     r2_num;
    logic [WORD_BITS-1:0]               r2_den;
    fpalu_pkg::t_flags                  r2_flags;

    logic                               w_ready1;
    logic                               w_ready2;
    logic [WORD_BITS-1:0]               n_res;
    logic [WORD_BITS-1:0]               w_mag_a;
    logic [WORD_BITS-1:0]               w_mag_b;
    logic                               w_div;
    logic                               w_dz;
    fpalu_pkg::t_flags                  n_flags;

    assign w_ready2 = !r2_valid || i_ready;
    assign w_ready1 = !r1_valid || w_ready2;
    assign o_ready  = w_ready1;
    assign w_prod   = PW'(i_a) * PW'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_ready1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1 && i_valid) begin
            r1_cmd  <= i_cmd;
            r1_a    <= i_a;
            r1_b    <= i_b;
            r1_prod <= w_prod;
        end
    end

    assign w_mag_a = r1_a[WORD_BITS-1] ? (~r1_a + WORD_BITS'(1)) : r1_a;
    assign w_mag_b = r1_b[WORD_BITS-1] ? (~r1_b + WORD_BITS'(1)) : r1_b;
    assign w_div   = (r1_cmd == fpalu_pkg::CMD_DIV);
    assign w_dz    = w_div && (r1_b == '0);

    always_comb begin
        n_flags.gt     = (r1_a > r1_b);
        n_flags.lt     = (r1_a < r1_b);
        n_flags.eq     = (r1_a == r1_b);
        n_flags.dz     = w_dz;
        n_flags.neg    = r1_a[WORD_BITS-1] ^ r1_b[WORD_BITS-1];
        n_flags.is_div = w_div && !w_dz;
    end

    always_comb begin
        unique case (r1_cmd)
            fpalu_pkg::CMD_ADD:      n_res = r1_a + r1_b;
            fpalu_pkg::CMD_SUB:      n_res = r1_a - r1_b;
            fpalu_pkg::CMD_MUL:      n_res = r1_prod[WORD_BITS+FRAC_BITS-1:FRAC_BITS];
            fpalu_pkg::CMD_MIN:      n_res = n_flags.lt ? r1_a : r1_b;
            fpalu_pkg::CMD_MAX:      n_res = n_flags.gt ? r1_a : r1_b;
            fpalu_pkg::CMD_FROM_INT: n_res = r1_a << FRAC_BITS;
            fpalu_pkg::CMD_TO_INT:   n_res = r1_a >>> FRAC_BITS;
            fpalu_pkg::CMD_INC:      n_res = r1_a + WORD_BITS'(1);
            fpalu_pkg::CMD_DEC:      n_res = r1_a - WORD_BITS'(1);
            default:                 n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_ready2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready2 && r1_valid) begin
            r2_res   <= n_res;
            r2_num   <= {w_mag_a, {FRAC_BITS{1'b0}}};
            r2_den   <= w_mag_b;
            r2_flags <= n_flags;
        end
    end

    assign o_valid = r2_valid;
    assign o_res   = r2_res;
    assign o_num   = r2_num;
    assign o_den   = r2_den;
    assign o_flags = r2_flags;

endmodule

// ===== rtl/fpalu_cell.sv =====
`timescale 1ns / 1ps

module fpalu_cell #(
    parameter int WORD_BITS = fpalu_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = fpalu_pkg::DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [WORD_BITS-1:0]            i_rem,
    input  logic [WORD_BITS+FRAC_BITS-1:0]  i_num,
    input  logic [WORD_BITS-1:0]            i_quo,
    input  logic [WORD_BITS-1:0]            i_den,
    input  logic [WORD_BITS-1:0]            i_res,
    input  fpalu_pkg::t_flags               i_flags,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [WORD_BITS-1:0]            o_rem,
    output logic [WORD_BITS+FRAC_BITS-1:0]  o_num,
    output logic [WORD_BITS-1:0]            o_quo,
    output logic [WORD_BITS-1:0]            o_den,
    output logic [WORD_BITS-1:0]            o_res,
    output fpalu_pkg::t_flags               o_flags
);

    localparam int NB = WORD_BITS + FRAC_BITS;

    logic                   r_valid;
    logic [WORD_BITS-1:0]   r_rem;
    logic [NB-1:0]          r_num;
    logic [WORD_BITS-1:0]   r_quo;
    logic [WORD_BITS-1:0]   r_den;
    logic [WORD_BITS-1:0]   r_res;
    fpalu_pkg::t_flags      r_flags;

    logic [WORD_BITS:0]     w_trial;
    logic [WORD_BITS:0]     w_diff;
    logic                   w_ge;
    logic                   w_ready;
    logic [WORD_BITS-1:0]   n_rem;

    // One restoring step: bring down the next numerator bit and subtract if it fits.
    assign w_trial = {i_rem, i_num[NB-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});
    assign n_rem   = w_ge ? w_diff[WORD_BITS-1:0] : w_trial[WORD_BITS-1:0];
    assign w_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_rem   <= n_rem;
            r_num   <= {i_num[NB-2:0], 1'b0};
            r_quo   <= {i_quo[WORD_BITS-2:0], w_ge};
            r_den   <= i_den;
            r_res   <= i_res;
            r_flags <= i_flags;
        end
    end

    assign o_ready = w_ready;
    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_den   = r_den;
    assign o_res   = r_res;
    assign o_flags = r_flags;

endmodule

// ===== rtl/fixed_point_q24_8_alu.sv =====
`timescale 1ns / 1ps

// Signed fixed-point ALU, WORD_BITS wide with FRAC_BITS fraction bits (Q24.8 by default).
// Requests enter on the s_axis channel: s_axis_tuser carries the operation code and
// s_axis_tdata carries operand_a in the low word and operand_b in the next word.
// Results leave on the m_axis channel: m_axis_tdata holds the result word and
// m_axis_tuser holds a_greater, a_less, a_equal and divide_by_zero, lowest bit first.
// Every request yields exactly one result, in request order.
// All operations share one path: two setup stages (multiply, decode, operand
// magnitudes), one divider cell per numerator bit, and the output register.
// Throughput is one request per cycle while m_axis_tready does not stall.
// The longest paths are the multiplier and the ready chain, which runs
// combinationally from m_axis_tready back through every stage.
// Each stage holds its data while the stage after it is full and stalled, so a stall on
// m_axis_tready fills the bubbles first and then pushes back through s_axis_tready.
// A synchronous low on i_rst_n empties every stage; no request is in flight after it.

module fixed_point_q24_8_alu #(
    parameter int WORD_BITS = fpalu_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = fpalu_pkg::DEF_FRAC_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // operand_a, operand_b, zero fill
    input  logic [((2*WORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // cmd
    input  logic [fpalu_pkg::CMD_BITS-1:0]          s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // result, zero fill
    output logic [((WORD_BITS+7)/8)*8-1:0]          m_axis_tdata,
    // a_greater, a_less, a_equal, divide_by_zero
    output logic [fpalu_pkg::USER_BITS-1:0]         m_axis_tuser
);

    localparam int NCELL = WORD_BITS + FRAC_BITS;
    localparam int OB    = ((WORD_BITS + 7) / 8) * 8;

    logic                       w_valid [0:NCELL];
    logic                       w_ready [0:NCELL];
    logic [WORD_BITS-1:0]       w_rem   [0:NCELL];
    logic [NCELL-1:0]           w_num   [0:NCELL];
    logic [WORD_BITS-1:0]       w_quo   [0:NCELL];
    logic [WORD_BITS-1:0]       w_den   [0:NCELL];
    logic [WORD_BITS-1:0]       w_res   [0:NCELL];
    fpalu_pkg::t_flags          w_flags [0:NCELL];

    logic                       r_out_valid;
    logic [WORD_BITS-1:0]       r_out_res;
    fpalu_pkg::t_flags          r_out_flags;
    logic [WORD_BITS-1:0]       w_quo_signed;
    logic [WORD_BITS-1:0]       n_out_res;
    logic                       w_out_ready;

    fpalu_prep #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser),
        .i_a     (s_axis_tdata[WORD_BITS-1:0]),
        .i_b     (s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_res   (w_res[0]),
        .o_num   (w_num[0]),
        .o_den   (w_den[0]),
        .o_flags (w_flags[0])
    );

    assign w_rem[0] = '0;
    assign w_quo[0] = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        fpalu_cell #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_rem   (w_rem[k]),
            .i_num   (w_num[k]),
            .i_quo   (w_quo[k]),
            .i_den   (w_den[k]),
            .i_res   (w_res[k]),
            .i_flags (w_flags[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_num   (w_num[k+1]),
            .o_quo   (w_quo[k+1]),
            .o_den   (w_den[k+1]),
            .o_res   (w_res[k+1]),
            .o_flags (w_flags[k+1])
        );
    end

    assign w_out_ready    = !r_out_valid || m_axis_tready;
    assign w_ready[NCELL] = w_out_ready;
    assign w_quo_signed   = w_flags[NCELL].neg ? (~w_quo[NCELL] + WORD_BITS'(1))
                                               : w_quo[NCELL];
    assign n_out_res      = w_flags[NCELL].is_div ? w_quo_signed : w_res[NCELL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_valid[NCELL]) begin
            r_out_res   <= n_out_res;
            r_out_flags <= w_flags[NCELL];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OB'(r_out_res);
    assign m_axis_tuser  = {r_out_flags.dz, r_out_flags.eq, r_out_flags.lt, r_out_flags.gt};

endmodule

// ===== rtl/fpalu_checker.sv =====
`timescale 1ns / 1ps

`include "fixed_point_q24_8_alu_assert.svh"

module fpalu_checker #(
    parameter int WORD_BITS = fpalu_pkg::DEF_WORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [((WORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    input  logic [fpalu_pkg::USER_BITS-1:0]     m_axis_tuser
);

    // Exactly one of greater, less and equal describes any pair of operands.
    `FPALU_ASSERT(a_cmp_onehot, i_clk, i_rst_n, m_axis_tvalid |-> $countones(m_axis_tuser[2:0]) == 1)

    // A divide by zero returns a zero word.
    `FPALU_ASSERT(a_dz_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tdata == '0)

    // A stalled result stays in place.
    `FPALU_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Reset drains the pipeline.
    `FPALU_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind fixed_point_q24_8_alu fpalu_checker #(
    .WORD_BITS (WORD_BITS)
) u_fpalu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
